// File: src/bas_pkg.sv
`default_nettype none
package bas_pkg;
   localparam int COUNT_BITS_DEF = 24;
   localparam int CODE_SPACE_DEF = 256;
   localparam int CODE_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGIT_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_CASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_SPACES = 3'd4;

   localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;

   // Request passed from front to back
   typedef struct packed {
      logic             is_end;
      logic [CODE_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic [16:0] threshold_frac;
      logic [15:0] digit_gain;
      logic [15:0] letter_gain;
      logic        fold_case;
      logic        merge_spaces;
   } cfg_type;

   function automatic logic is_digit(input logic [CODE_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [CODE_W-1:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction
endpackage
`default_nettype wire

// File: src/byte_alphabet_selector.sv
`default_nettype none
// Channel  Ports                               Handshake
// req      req_kind, req_text_byte             req_push / req_full
// rsp      rsp_chunk .. rsp_last               rsp_pop / rsp_empty
// csr      csr_index, csr_data                 csr_valid / csr_ready
// A text byte is one histogram read-modify-write on the single RAM port pair.
// An end request waits for the last count write, then computes the min product, walks
// the bins twice and gives four results (one failed result if nothing was counted), then
// a clearing pass that also follows reset. The engine takes nothing meanwhile; a four-entry
// queue parts the classifier from the histogram engine and req_full rises once it fills.
module byte_alphabet_selector
   import bas_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int CODE_SPACE = CODE_SPACE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_kind,
   input  wire logic [7:0]            req_text_byte,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [1:0]                 rsp_chunk,
   output logic [63:0]                rsp_alphabet_mask,
   output logic [63:0]                rsp_collapsed_mask,
   output logic [7:0]                 rsp_representative,
   output logic                       rsp_has_representative,
   output logic [8:0]                 rsp_alphabet_len,
   output logic [8:0]                 rsp_collapsed_len,
   output logic                       rsp_failed,
   output logic                       rsp_last,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);
   cfg_type cfg_ff;
   cmd_type q_data;
   logic    q_valid, q_take, busy;

   assign csr_ready = 1'b1;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_frac <= '0;
         cfg_ff.digit_gain <= 16'd256;
         cfg_ff.letter_gain <= 16'd256;
         cfg_ff.fold_case <= 1'b0;
         cfg_ff.merge_spaces <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:    cfg_ff.threshold_frac <= csr_data;
            CSR_DIGIT_GAIN:   cfg_ff.digit_gain <= csr_data[15:0];
            CSR_LETTER_GAIN:  cfg_ff.letter_gain <= csr_data[15:0];
            CSR_FOLD_CASE:    cfg_ff.fold_case <= csr_data[0];
            CSR_MERGE_SPACES: cfg_ff.merge_spaces <= csr_data[0];
            default: ;
         endcase
      end
   end

   bas_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_push(req_push), .req_full(req_full), .req_kind(req_kind),
      .req_text_byte(req_text_byte),
      .q_data(q_data), .q_valid(q_valid), .q_take(q_take)
   );

   bas_back #(.COUNT_BITS(COUNT_BITS), .CODE_SPACE(CODE_SPACE)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_data(q_data), .q_valid(q_valid), .q_take(q_take), .busy(busy),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_chunk(rsp_chunk),
      .rsp_alphabet_mask(rsp_alphabet_mask), .rsp_collapsed_mask(rsp_collapsed_mask),
      .rsp_representative(rsp_representative),
      .rsp_has_representative(rsp_has_representative),
      .rsp_alphabet_len(rsp_alphabet_len), .rsp_collapsed_len(rsp_collapsed_len),
      .rsp_failed(rsp_failed), .rsp_last(rsp_last)
   );

   // A failed result is always the only one of its run
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_failed) |-> (rsp_last && rsp_chunk == 2'd0))
      else $error("failed result not last");
   // Results show only while the engine is busy with an end request
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> busy)
      else $error("result while engine idle");
   // A failed result carries no lengths
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_failed) |-> (rsp_alphabet_len == '0 && rsp_collapsed_len == '0))
      else $error("failed result with lengths");
endmodule
`default_nettype wire

// File: src/bas_ram.sv
`default_nettype none
module bas_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: src/bas_front.sv
`default_nettype none
module bas_front
   import bas_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_text_byte,
   output cmd_type          q_data,
   output logic             q_valid,
   input  wire logic        q_take
);
   localparam int QD = 4;
   localparam int QW = $clog2(QD);

   cmd_type           q_ff [QD];
   logic [QW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [QW:0]       cnt_ff, cnt_in;
   logic [CODE_W-1:0] prev_ff, prev_in;
   cmd_type           cmd;
   logic              drop, accept;

   assign req_full = (cnt_ff == QW'(0) + (QW+1)'(QD));
   assign accept = req_push && !req_full;

   // Classify: map whitespace, drop repeated spaces, fold case
   always_comb begin
      cmd.is_end = req_kind;
      cmd.code = req_text_byte;
      drop = 1'b0;
      if (!req_kind) begin
         if (cfg.merge_spaces && (((req_text_byte >= 8'd9) && (req_text_byte <= 8'd13))
                                  || (req_text_byte == SPACE_CODE))) begin
            cmd.code = SPACE_CODE;
            drop = (prev_ff == SPACE_CODE);
         end
         if (cfg.fold_case && (cmd.code >= 8'h41) && (cmd.code <= 8'h5A)) begin
            cmd.code = cmd.code + 8'd32;
         end
      end
   end

   always_comb begin
      prev_in = prev_ff;
      if (accept) begin
         if (req_kind) begin
            prev_in = '0;
         end else if (!drop) begin
            prev_in = cmd.code;
         end
      end
   end

   wire push_q = accept && !(drop && !req_kind);
   wire pop_q = q_take && q_valid;

   assign wp_in = push_q ? wp_ff + QW'(1) : wp_ff;
   assign rp_in = pop_q ? rp_ff + QW'(1) : rp_ff;
   assign cnt_in = cnt_ff + (QW+1)'(push_q) - (QW+1)'(pop_q);
   assign q_valid = (cnt_ff != '0);
   assign q_data = q_ff[rp_ff];

   // Advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         prev_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         q_ff[wp_ff] <= cmd;
      end
   end
endmodule
`default_nettype wire

// File: src/bas_back.sv
`default_nettype none
module bas_back
   import bas_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int CODE_SPACE = CODE_SPACE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire cmd_type     q_data,
   input  wire logic        q_valid,
   output logic             q_take,
   output logic             busy,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_chunk,
   output logic [63:0]      rsp_alphabet_mask,
   output logic [63:0]      rsp_collapsed_mask,
   output logic [7:0]       rsp_representative,
   output logic             rsp_has_representative,
   output logic [8:0]       rsp_alphabet_len,
   output logic [8:0]       rsp_collapsed_len,
   output logic             rsp_failed,
   output logic             rsp_last
);
   localparam int AW = $clog2(CODE_SPACE);
   localparam int SW = AW + 1;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam int PW = COUNT_BITS + 17;
   localparam int GW = COUNT_BITS + 16;

   localparam logic [3:0] ST_COUNT = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_MIN   = 4'd2;
   localparam logic [3:0] ST_P1    = 4'd3;
   localparam logic [3:0] ST_P2    = 4'd4;
   localparam logic [3:0] ST_OUT   = 4'd5;
   localparam logic [3:0] ST_FAIL  = 4'd6;

   logic [3:0]   st_ff, st_in;
   logic [SW-1:0] idx_ff, idx_in;
   // Delayed address and valid for registered reads / rmw
   logic [AW-1:0] a1_ff, a2_ff;
   logic          v1_ff, v2_ff;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS:0]   min_ff;
   logic [PW-1:0]         prod_ff;
   logic [COUNT_BITS-1:0] best_ff, best_in;
   logic [AW-1:0]         bcode_ff, bcode_in;
   logic [63:0] kept_ff [4];
   logic [63:0] coll_ff [4];
   logic [8:0]  alen_ff, clen_ff;
   logic [1:0]  oc_ff;
   // Pending count increments (write bypass)
   logic          pv_ff;
   logic [AW-1:0] pa_ff;
   logic [COUNT_BITS-1:0] pd_ff;
   logic [GW-1:0] scl_ff;
   logic [COUNT_BITS-1:0] cnt2_ff;

   logic               we;
   logic [AW-1:0]      wa, ra;
   logic [COUNT_BITS-1:0] wd, rd;

   bas_ram #(.WIDTH(COUNT_BITS), .DEPTH(CODE_SPACE)) u_hist (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   // Count stage: read in cycle of take, modify-write next cycle
   wire take_byte = (st_ff == ST_COUNT) && q_valid && !q_data.is_end;
   wire take_end  = (st_ff == ST_COUNT) && q_valid && q_data.is_end && !pv_ff;
   assign q_take = take_byte || take_end;
   assign busy = (st_ff != ST_COUNT) || pv_ff;

   wire [COUNT_BITS-1:0] cur = (pv_ff && v1_ff && (a1_ff == pa_ff)) ? pd_ff : rd;
   wire [COUNT_BITS-1:0] inc = (cur == CMAX) ? cur : cur + COUNT_BITS'(1);

   always_comb begin
      ra = idx_ff[AW-1:0];
      if (st_ff == ST_COUNT) begin
         ra = q_data.code;
      end
      we = 1'b0;
      wa = a1_ff;
      wd = inc;
      if ((st_ff == ST_COUNT) && v1_ff) begin
         we = 1'b1;
      end else if (st_ff == ST_CLEAR) begin
         we = 1'b1;
         wa = idx_ff[AW-1:0];
         wd = '0;
      end
   end

   // Threshold product for min
   wire [PW-1:0] mprod = PW'(cfg.threshold_frac) * PW'(total_ff);
   wire [PW-1:0] mceil = (prod_ff + PW'(16'hFFFF)) >> 16;
   wire [COUNT_BITS:0] mval = (mceil == '0) ? (COUNT_BITS+1)'(1) : (COUNT_BITS+1)'(mceil);

   // Adjusted count for the bin read last cycle
   wire [7:0] c1 = 8'(a1_ff);
   wire [15:0] gain = is_digit(c1) ? cfg.digit_gain : cfg.letter_gain;
   wire scaled = is_digit(c1) || is_letter(c1);
   wire [GW-1:0] sprod = GW'(rd) * GW'(gain);
   wire [GW-1:0] adj2 = (scl_ff + GW'(128)) >> 8;
   wire [7:0] c2 = 8'(a2_ff);
   wire [GW-1:0] adjv = (is_digit(c2) || is_letter(c2)) ? adj2 : GW'(cnt2_ff);
   wire below = adjv < GW'(min_ff);

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      total_in = total_ff;
      best_in = best_ff;
      bcode_in = bcode_ff;
      case (st_ff)
         ST_COUNT: begin
            if (take_byte && (total_ff != CMAX)) begin
               total_in = total_ff + COUNT_BITS'(1);
            end
            if (take_end) begin
               idx_in = '0;
               best_in = '0;
               bcode_in = '0;
               st_in = (total_ff == '0) ? ST_FAIL : ST_MIN;
            end
         end
         ST_MIN: st_in = ST_P1;
         ST_P1, ST_P2: begin
            if (idx_ff != SW'(CODE_SPACE)) begin
               idx_in = idx_ff + SW'(1);
            end
            if ((st_ff == ST_P1) && v2_ff && (cnt2_ff != '0) && below
                && (cnt2_ff > best_ff)) begin
               best_in = cnt2_ff;
               bcode_in = a2_ff;
            end
            if ((idx_ff == SW'(CODE_SPACE)) && !v1_ff && !v2_ff) begin
               idx_in = '0;
               st_in = (st_ff == ST_P1) ? ST_P2 : ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_pop && (oc_ff == 2'd3)) begin
               idx_in = '0;
               st_in = ST_CLEAR;
            end
         end
         ST_FAIL: begin
            if (rsp_pop) begin
               idx_in = '0;
               st_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            idx_in = idx_ff + SW'(1);
            if (idx_ff == SW'(CODE_SPACE - 1)) begin
               st_in = ST_COUNT;
               total_in = '0;
            end
         end
         default: st_in = ST_COUNT;
      endcase
   end

   wire walk = ((st_ff == ST_P1) || (st_ff == ST_P2)) && (idx_ff != SW'(CODE_SPACE));
   wire has_rep = (best_ff != '0);
   wire p2_hit = (st_ff == ST_P2) && v2_ff && (cnt2_ff != '0)
                 && !(has_rep && (a2_ff == bcode_ff));

   // Advance control
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         idx_ff <= '0;
         total_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         pv_ff <= 1'b0;
         oc_ff <= '0;
      end else begin
         st_ff <= st_in;
         idx_ff <= idx_in;
         total_ff <= total_in;
         v1_ff <= take_byte || walk;
         v2_ff <= v1_ff && (st_ff != ST_COUNT);
         pv_ff <= (st_ff == ST_COUNT) && v1_ff;
         if (st_ff == ST_OUT) begin
            if (rsp_pop) oc_ff <= oc_ff + 2'd1;
         end else begin
            oc_ff <= '0;
         end
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      a1_ff <= ra;
      a2_ff <= a1_ff;
      pa_ff <= a1_ff;
      pd_ff <= inc;
      cnt2_ff <= rd;
      scl_ff <= scaled ? sprod : '0;
      prod_ff <= mprod;
      best_ff <= best_in;
      bcode_ff <= bcode_in;
      if (st_ff == ST_P1) begin
         min_ff <= min_ff;
      end
      if (st_ff == ST_MIN) begin
         min_ff <= mval;
      end
      if (take_end) begin
         alen_ff <= '0;
         clen_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            kept_ff[k] <= '0;
            coll_ff[k] <= '0;
         end
      end else if (st_ff == ST_MIN) begin
         alen_ff <= '0;
      end else if ((st_ff == ST_P2) && (idx_ff == '0) && !v1_ff && !v2_ff) begin
         alen_ff <= 9'(has_rep);
      end else if (p2_hit) begin
         if (!below) begin
            kept_ff[a2_ff[AW-1:6]][a2_ff[5:0]] <= 1'b1;
            alen_ff <= alen_ff + 9'd1;
         end else begin
            coll_ff[a2_ff[AW-1:6]][a2_ff[5:0]] <= 1'b1;
            clen_ff <= clen_ff + 9'd1;
         end
      end
   end

   // Drive results
   wire fail = (st_ff == ST_FAIL);
   assign rsp_empty = !((st_ff == ST_OUT) || fail);
   assign rsp_chunk = fail ? 2'd0 : oc_ff;
   assign rsp_alphabet_mask = fail ? '0 : kept_ff[oc_ff];
   assign rsp_collapsed_mask = fail ? '0 : coll_ff[oc_ff];
   assign rsp_representative = (fail || !has_rep) ? '0 : 8'(bcode_ff);
   assign rsp_has_representative = !fail && has_rep;
   assign rsp_alphabet_len = fail ? '0 : alen_ff;
   assign rsp_collapsed_len = fail ? '0 : clen_ff;
   assign rsp_failed = fail;
   assign rsp_last = fail || (oc_ff == 2'd3);
endmodule
`default_nettype wire
